>>> sv/crm_pkg.sv
package crm_pkg;

  localparam int unsigned CountW = 64;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned RateW  = 32;
  localparam int unsigned DigitW = 4;
  localparam int unsigned MhzW   = 14;
  localparam int unsigned BcdW   = 16;
  localparam int unsigned StepW  = 5;

  // Last step index of each shift unit; the step counter counts from zero
  localparam logic [StepW-1:0] DivLastStep = 5'd31;
  localparam logic [StepW-1:0] BcdLastStep = 5'd13;

  // Rounding to MHz: (rate + 500) / 1000 by reciprocal multiply, exact below 2^24
  localparam logic [RateW:0]   RoundBias = 33'd500;
  localparam logic [RateW:0]   SatSum    = 33'd10_000_000;
  localparam logic [24:0]      MhzRecip  = 25'd17_179_870;
  localparam int unsigned      MhzShift  = 34;
  localparam logic [MhzW-1:0]  MhzMax    = 14'd9999;

  localparam logic [DigitW-1:0] DigitMhz   = 4'd10;
  localparam logic [DigitW-1:0] DigitBlank = 4'd11;
  localparam logic [DigitW-1:0] DigitZero  = 4'd0;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul;
    logic bcd_load;
    logic bcd_step;
    logic out_load;
  } crm_cmd_t;

  typedef struct packed {
    logic rate_zero;
  } crm_sts_t;

endpackage

>>> sv/crm_ctrl.sv
module crm_ctrl
  import crm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  crm_sts_t sts,
  output crm_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_BLD,
    ST_BCD,
    ST_FIN
  } state_t;

  state_t           state_r;
  logic [StepW-1:0] cnt_r;
  logic             out_valid_r;
  logic             out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: cmd.load     = in_valid;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_MUL:  cmd.mul      = 1'b1;
      ST_BLD:  cmd.bcd_load = 1'b1;
      ST_BCD:  cmd.bcd_step = 1'b1;
      ST_FIN:  cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // raise valid on the final write, drop it once the result transfers
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (in_valid) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == DivLastStep) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          // skip the digit work when the rate is zero
          state_r <= sts.rate_zero ? ST_FIN : ST_BLD;
        end
        ST_BLD: begin
          cnt_r   <= '0;
          state_r <= ST_BCD;
        end
        ST_BCD: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == BcdLastStep) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sv/crm_dp.sv
module crm_dp
  import crm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  crm_cmd_t          cmd,
  output crm_sts_t          sts,
  input  logic [CountW-1:0] in_cycle_count,
  input  logic [TimeW-1:0]  in_time_ms,
  input  logic              in_force_refresh,
  output logic [RateW-1:0]  out_rate_khz,
  output logic              out_display_valid,
  output logic [DigitW-1:0] out_digit_a,
  output logic [DigitW-1:0] out_digit_b,
  output logic [DigitW-1:0] out_digit_c,
  output logic [DigitW-1:0] out_digit_d,
  output logic              out_refresh_upper_pair,
  output logic              out_refresh_lower_pair
);

  logic [CountW-1:0] last_c_r;
  logic [TimeW-1:0]  last_t_r;
  logic [7:0]        shown_up_r;
  logic [7:0]        shown_lo_r;

  logic [TimeW-1:0]  rem_r;
  logic [RateW-1:0]  quo_r;
  logic [TimeW-1:0]  den_r;
  logic              ok_r;
  logic              force_r;
  logic [48:0]       prod_r;
  logic              big_r;
  logic [MhzW-1:0]   bin_r;
  logic [BcdW-1:0]   bcd_r;

  logic [RateW-1:0]  rate_khz_r;
  logic              display_valid_r;
  logic [DigitW-1:0] digit_a_r, digit_b_r, digit_c_r, digit_d_r;
  logic              refresh_up_r, refresh_lo_r;

  logic [CountW-1:0] dc;
  logic [TimeW-1:0]  dt;
  logic [TimeW:0]    trial;
  logic              qbit;
  logic [RateW-1:0]  rate;
  logic [RateW:0]    sum;
  logic [BcdW-1:0]   bcd_adj;
  logic [DigitW-1:0] th, hu, te, un;
  logic [DigitW-1:0] d0, d1, d2, d3;

  assign dc    = in_cycle_count - last_c_r;
  assign dt    = in_time_ms - last_t_r;
  assign trial = {rem_r, quo_r[RateW-1]};
  assign qbit  = (trial >= {1'b0, den_r});
  assign rate  = ok_r ? quo_r : '0;
  assign sum   = {1'b0, rate} + RoundBias;
  assign sts.rate_zero = (rate == '0);

  always_comb begin
    for (int i = 0; i < BcdW / DigitW; i++) begin
      bcd_adj[i*DigitW +: DigitW] = (bcd_r[i*DigitW +: DigitW] >= 4'd5)
          ? bcd_r[i*DigitW +: DigitW] + 4'd3 : bcd_r[i*DigitW +: DigitW];
    end
  end

  assign th = bcd_r[15:12];
  assign hu = bcd_r[11:8];
  assign te = bcd_r[7:4];
  assign un = bcd_r[3:0];

  always_comb begin
    if (th != DigitZero) begin
      d0 = th;
      d1 = hu;
      d2 = te;
      d3 = un;
    end else begin
      d0 = (hu == DigitZero) ? DigitBlank : hu;
      d1 = (hu == DigitZero && te == DigitZero) ? DigitBlank : te;
      d2 = un;
      d3 = DigitMhz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_c_r   <= '0;
      last_t_r   <= '0;
      shown_up_r <= '0;
      shown_lo_r <= '0;
    end else begin
      if (cmd.load) begin
        last_c_r <= in_cycle_count;
        last_t_r <= in_time_ms;
      end
      if (cmd.out_load && !sts.rate_zero) begin
        shown_up_r <= {d0, d1};
        shown_lo_r <= {d2, d3};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ok_r    <= (dt > dc[CountW-1:RateW]);
      rem_r   <= dc[CountW-1:RateW];
      quo_r   <= dc[RateW-1:0];
      den_r   <= dt;
      force_r <= in_force_refresh;
    end
    if (cmd.div_step) begin
      rem_r <= qbit ? TimeW'(trial - {1'b0, den_r}) : trial[TimeW-1:0];
      quo_r <= {quo_r[RateW-2:0], qbit};
    end
    if (cmd.mul) begin
      big_r  <= (sum >= SatSum);
      prod_r <= sum[23:0] * MhzRecip;
    end
    if (cmd.bcd_load) begin
      bin_r <= big_r ? MhzMax : prod_r[MhzShift +: MhzW];
      bcd_r <= '0;
    end
    if (cmd.bcd_step) begin
      bcd_r <= {bcd_adj[BcdW-2:0], bin_r[MhzW-1]};
      bin_r <= {bin_r[MhzW-2:0], 1'b0};
    end
    if (cmd.out_load) begin
      rate_khz_r <= rate;
      if (sts.rate_zero) begin
        display_valid_r <= 1'b0;
        digit_a_r       <= DigitZero;
        digit_b_r       <= DigitZero;
        digit_c_r       <= DigitZero;
        digit_d_r       <= DigitZero;
        refresh_up_r    <= 1'b0;
        refresh_lo_r    <= 1'b0;
      end else begin
        display_valid_r <= 1'b1;
        digit_a_r       <= d0;
        digit_b_r       <= d1;
        digit_c_r       <= d2;
        digit_d_r       <= d3;
        refresh_up_r    <= force_r || ({d0, d1} != shown_up_r);
        refresh_lo_r    <= force_r || ({d2, d3} != shown_lo_r);
      end
    end
  end

  assign out_rate_khz           = rate_khz_r;
  assign out_display_valid      = display_valid_r;
  assign out_digit_a            = digit_a_r;
  assign out_digit_b            = digit_b_r;
  assign out_digit_c            = digit_c_r;
  assign out_digit_d            = digit_d_r;
  assign out_refresh_upper_pair = refresh_up_r;
  assign out_refresh_lower_pair = refresh_lo_r;

endmodule

>>> sv/cycle_rate_meter_with_digit_format.sv
// Cycle-rate meter. Each input transfer carries a 64-bit cycle count and a
// 32-bit millisecond time; the block subtracts the previous sample (with wrap),
// divides count delta by time delta to give kHz, and returns one result per
// sample: the rate (0 when the time delta is not above the upper count word),
// four display digit codes for the rate rounded to MHz (10 = MHz glyph,
// 11 = blank, saturated at 9999 MHz), and a refresh flag per digit pair that
// is raised, for a nonzero rate, when the pair changed since the last shown
// value or when forced. One sample occupies the block from taking the
// transfer through the bit-serial restoring divider, the reciprocal multiply
// that rounds to MHz, the load of the binary-to-BCD converter and its
// shift-add-3 steps to the write of the output register. A zero rate skips
// the digit steps. The next sample is taken while a finished result still
// waits in the output register; a waiting result only holds the final write
// step.
module cycle_rate_meter_with_digit_format
  import crm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CountW-1:0] in_cycle_count,
  input  logic [TimeW-1:0]  in_time_ms,
  input  logic              in_force_refresh,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [RateW-1:0]  out_rate_khz,
  output logic              out_display_valid,
  output logic [DigitW-1:0] out_digit_a,
  output logic [DigitW-1:0] out_digit_b,
  output logic [DigitW-1:0] out_digit_c,
  output logic [DigitW-1:0] out_digit_d,
  output logic              out_refresh_upper_pair,
  output logic              out_refresh_lower_pair
);

  crm_cmd_t cmd;
  crm_sts_t sts;

  // Sequencer: owns the handshakes and the step counter
  crm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: sample history, divider, MHz rounding, BCD split, output register
  crm_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_cycle_count         (in_cycle_count),
    .in_time_ms             (in_time_ms),
    .in_force_refresh       (in_force_refresh),
    .out_rate_khz           (out_rate_khz),
    .out_display_valid      (out_display_valid),
    .out_digit_a            (out_digit_a),
    .out_digit_b            (out_digit_b),
    .out_digit_c            (out_digit_c),
    .out_digit_d            (out_digit_d),
    .out_refresh_upper_pair (out_refresh_upper_pair),
    .out_refresh_lower_pair (out_refresh_lower_pair)
  );

`ifndef SYNTHESIS
  // The display is marked valid exactly when the rate is nonzero
  a_disp_matches_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_display_valid == (out_rate_khz != '0)))
    else $error("display_valid disagrees with rate_khz");

  // Hold off new samples right after one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("sample taken while previous one is in progress");

  // A zero rate carries zero outer digits and no refresh
  a_zero_rate_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_display_valid) |->
      (out_digit_a == '0 && out_digit_d == '0 &&
       !out_refresh_upper_pair && !out_refresh_lower_pair))
    else $error("zero-rate result carries digit data");

  // Lower digits stay valid codes
  a_digit_codes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_display_valid) |->
      (out_digit_c <= 4'd9 && out_digit_d <= 4'd10))
    else $error("lower digit code out of range");
`endif

endmodule

>>> test/tb_cycle_rate_meter_with_digit_format.sv
`timescale 1ns / 100ps

module tb_cycle_rate_meter_with_digit_format;
  import crm_pkg::*;

  // One result transfer as a single packed word, in port order
  typedef struct packed {
    logic [RateW-1:0]  rate_khz;
    logic              display_valid;
    logic [DigitW-1:0] digit_a;
    logic [DigitW-1:0] digit_b;
    logic [DigitW-1:0] digit_c;
    logic [DigitW-1:0] digit_d;
    logic              refresh_upper_pair;
    logic              refresh_lower_pair;
  } reading_t;

  // Scoreboard: predict the reading of every accepted sample, then check the
  // readings in arrival order against the oldest prediction.
  class meter_scoreboard;
    reading_t          expected_readings[$];
    logic [CountW-1:0] prev_count;
    logic [TimeW-1:0]  prev_time;
    logic [7:0]        shown_upper;
    logic [7:0]        shown_lower;
    int                mismatches;
    int                checked;
    int                zero_rates;
    int                saturated;

    function new();
      prev_count  = '0;
      prev_time   = '0;
      shown_upper = '0;
      shown_lower = '0;
      mismatches  = 0;
      checked     = 0;
      zero_rates  = 0;
      saturated   = 0;
    endfunction

    function reading_t predict_reading(logic [CountW-1:0] cnt, logic [TimeW-1:0] tm,
                                       logic frc);
      logic [CountW-1:0] dcnt;
      logic [TimeW-1:0]  dtm;
      longint unsigned   mhz;
      logic [DigitW-1:0] d0, d1, d2, d3;
      reading_t          r;
      dcnt       = cnt - prev_count;
      dtm        = tm - prev_time;
      prev_count = cnt;
      prev_time  = tm;
      r          = '0;
      // a time delta above the upper count word rules out zero and overflow
      if (dtm > dcnt[63:32]) r.rate_khz = RateW'(dcnt / {32'd0, dtm});
      if (r.rate_khz == '0) return r;
      mhz = (longint'(r.rate_khz) + 500) / 1000;
      if (mhz > 9999) begin
        mhz = 9999;
        saturated++;
      end
      if (mhz >= 1000) begin
        d0 = DigitW'(mhz / 1000);
        d1 = DigitW'(mhz / 100 % 10);
        d2 = DigitW'(mhz / 10 % 10);
        d3 = DigitW'(mhz % 10);
      end else begin
        d0 = DigitW'(mhz / 100);
        d1 = DigitW'(mhz / 10 % 10);
        d2 = DigitW'(mhz % 10);
        d3 = DigitMhz;
      end
      if (mhz < 100) d0 = DigitBlank;
      if (mhz < 10) d1 = DigitBlank;
      r.display_valid      = 1'b1;
      r.digit_a            = d0;
      r.digit_b            = d1;
      r.digit_c            = d2;
      r.digit_d            = d3;
      r.refresh_upper_pair = ({d0, d1} != shown_upper) || frc;
      r.refresh_lower_pair = ({d2, d3} != shown_lower) || frc;
      shown_upper          = {d0, d1};
      shown_lower          = {d2, d3};
      return r;
    endfunction

    function void note_sample(logic [CountW-1:0] cnt, logic [TimeW-1:0] tm, logic frc);
      expected_readings.push_back(predict_reading(cnt, tm, frc));
    endfunction

    function string describe(reading_t r);
      return $sformatf("rate=%0d shown=%0b digits=%0d,%0d,%0d,%0d refresh=%0b/%0b",
                       r.rate_khz, r.display_valid, r.digit_a, r.digit_b, r.digit_c,
                       r.digit_d, r.refresh_upper_pair, r.refresh_lower_pair);
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      checked++;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("reading %0d with no sample pending: %s",
                                       checked, describe(got));
        return;
      end
      want = expected_readings.pop_front();
      if (want.rate_khz == '0) zero_rates++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("reading %0d mismatch: expected %s, got %s",
                                       checked, describe(want), describe(got));
      end
    endfunction

    function int outstanding();
      return expected_readings.size();
    endfunction
  endclass

  logic              clk                = 1'b0;
  logic              rst_n              = 1'b0;
  logic              in_valid           = 1'b0;
  logic              in_stall;
  logic [CountW-1:0] in_cycle_count     = '0;
  logic [TimeW-1:0]  in_time_ms         = '0;
  logic              in_force_refresh   = 1'b0;
  logic              out_valid;
  logic              out_stall          = 1'b0;
  logic [RateW-1:0]  out_rate_khz;
  logic              out_display_valid;
  logic [DigitW-1:0] out_digit_a;
  logic [DigitW-1:0] out_digit_b;
  logic [DigitW-1:0] out_digit_c;
  logic [DigitW-1:0] out_digit_d;
  logic              out_refresh_upper_pair;
  logic              out_refresh_lower_pair;

  meter_scoreboard   board;

  // Sender bookkeeping: the last sample offered, in acceptance order
  logic [CountW-1:0] last_sent_count = '0;
  logic [TimeW-1:0]  last_sent_time  = '0;
  logic [TimeW-1:0]  steady_dt       = 32'd1000;
  logic [RateW-1:0]  steady_khz      = 32'd2_400_000;
  int                samples_sent    = 0;
  // calm turns off random idling on both sides; receiver_hold forces a long stall
  bit                calm            = 1'b0;
  int                receiver_hold   = 0;

  cycle_rate_meter_with_digit_format dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_cycle_count         (in_cycle_count),
    .in_time_ms             (in_time_ms),
    .in_force_refresh       (in_force_refresh),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_rate_khz           (out_rate_khz),
    .out_display_valid      (out_display_valid),
    .out_digit_a            (out_digit_a),
    .out_digit_b            (out_digit_b),
    .out_digit_c            (out_digit_c),
    .out_digit_d            (out_digit_d),
    .out_refresh_upper_pair (out_refresh_upper_pair),
    .out_refresh_lower_pair (out_refresh_lower_pair)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Idle lengths: mostly none or short, now and then long, none while calm
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 6);
    return $urandom_range(15, 80);
  endfunction

  function automatic int pick_stall();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 5);
    return $urandom_range(10, 60);
  endfunction

  // Offer one sample after an optional gap and hold it until the transfer.
  // Called at a rising edge; valid gets at most one assignment per edge.
  task automatic send_sample(input logic [CountW-1:0] cnt, input logic [TimeW-1:0] tm,
                             input logic frc);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cycle_count   <= cnt;
    in_time_ms       <= tm;
    in_force_refresh <= frc;
    do @(posedge clk); while (in_stall);
    board.note_sample(cnt, tm, frc);
    last_sent_count = cnt;
    last_sent_time  = tm;
    samples_sent++;
  endtask

  // Advance time by dt ms and the cycle count by exactly dt * khz
  task automatic send_rate(input logic [TimeW-1:0] dt, input logic [RateW-1:0] khz,
                           input logic frc);
    send_sample(last_sent_count + 64'(dt) * 64'(khz), last_sent_time + dt, frc);
  endtask

  // Drop valid and wait until every predicted reading has been checked
  task automatic drain_readings();
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  // Mostly plausible meter traffic with random content; the rest is overflow,
  // zero time deltas and raw noise across all bits.
  task automatic random_traffic(input int n);
    int                kind;
    logic [TimeW-1:0]  dt;
    logic [RateW-1:0]  khz;
    logic [TimeW-1:0]  upper;
    logic              frc;
    repeat (n) begin
      kind = $urandom_range(0, 99);
      frc  = ($urandom_range(0, 9) == 0);
      if (kind < 80) begin
        if ($urandom_range(0, 5) == 0) begin
          // steady clock: same digits, so refresh stays low unless forced
          dt  = steady_dt;
          khz = steady_khz;
        end else begin
          case ($urandom_range(0, 9))
            0:       dt = $urandom;
            1, 2:    dt = $urandom_range(1, 20);
            default: dt = $urandom_range(1, 2000);
          endcase
          case ($urandom_range(0, 7))
            0:       khz = $urandom_range(0, 499);
            1:       khz = $urandom_range(500, 9_999);
            2:       khz = $urandom_range(10_000, 99_999);
            3:       khz = $urandom_range(100_000, 999_999);
            4:       khz = $urandom_range(10_000_000, 32'hFFFF_FFFF);
            default: khz = $urandom_range(1_000_000, 9_999_999);
          endcase
          // land on the rounding edge now and then
          if (khz < 32'd4_000_000_000 && $urandom_range(0, 4) == 0)
            khz = khz - khz % 1000 + ($urandom_range(0, 1) ? 32'd499 : 32'd500);
          steady_dt  = dt;
          steady_khz = khz;
        end
        // extra cycles below dt leave the quotient unchanged
        send_sample(last_sent_count + 64'(dt) * 64'(khz) + 64'($urandom_range(0, dt - 1)),
                    last_sent_time + dt, frc);
      end else if (kind < 88) begin
        // upper count word at or above the time delta: quotient overflow
        dt    = $urandom_range(1, 5000);
        upper = dt + $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) upper = $urandom_range(dt, 32'hFFFF_FFFF);
        send_sample(last_sent_count + {upper, 32'($urandom)}, last_sent_time + dt, frc);
      end else if (kind < 93) begin
        send_sample(last_sent_count + 64'($urandom), last_sent_time, frc);
      end else begin
        send_sample({32'($urandom), 32'($urandom)}, $urandom, frc);
      end
    end
  endtask

  // Result side: check every transfer, then pick the stall for the next cycle
  initial begin : reading_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        board.check_reading('{out_rate_khz, out_display_valid, out_digit_a, out_digit_b,
                              out_digit_c, out_digit_d, out_refresh_upper_pair,
                              out_refresh_lower_pair});
      if (receiver_hold > 0) begin
        out_stall <= 1'b1;
        receiver_hold--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall  <= 1'b0;
        stall_left = pick_stall();
      end
    end
  end

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first sample against the reset state (zero time delta)
    send_sample('0, '0, 1'b0);
    // rounding edges through every digit width
    send_rate(1, 499, 1'b0);
    send_rate(1, 500, 1'b0);
    send_rate(1, 500, 1'b0);
    send_rate(1, 500, 1'b1);
    send_rate(7, 9_499, 1'b0);
    send_rate(3, 9_500, 1'b0);
    send_rate(1000, 99_499, 1'b0);
    send_rate(1000, 99_500, 1'b0);
    send_rate(2, 999_499, 1'b0);
    send_rate(2, 999_500, 1'b0);
    send_rate(1, 9_999_499, 1'b0);
    // display saturation, then the largest rate the block can report
    send_rate(1, 9_999_500, 1'b0);
    send_rate(1, 32'hFFFF_FFFF, 1'b1);
    // longest time delta
    send_rate(32'hFFFF_FFFF, 1, 1'b0);
    // upper count word equals the time delta: overflow gives zero
    send_sample(last_sent_count + 64'h1_0000_0000, last_sent_time + 1, 1'b0);
    // zero time delta with a forced refresh: force must not matter
    send_sample(last_sent_count + 64'd12_345, last_sent_time, 1'b1);
    send_sample('1, '1, 1'b1);
    // both counters wrap through zero
    send_rate(1000, 3_000_000, 1'b0);
    send_rate(5, 0, 1'b1);
    send_sample('0, '0, 1'b0);

    random_traffic(600);

    // no idling on either side
    calm = 1'b1;
    random_traffic(300);

    // hold the result side for a long stretch while samples keep coming
    receiver_hold = 400;
    random_traffic(12);
    calm = 1'b0;
    drain_readings();
    repeat ($urandom_range(1, 30)) @(posedge clk);

    random_traffic(1088);

    drain_readings();
    repeat (60) @(posedge clk);

    $display("Sent %0d samples, checked %0d readings: %0d zero rates, %0d saturated displays.",
             samples_sent, board.checked, board.zero_rates, board.saturated);
    $display("Covered rounding edges, counter wrap, overflow, forced and steady refresh.");
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/crm_pkg.sv
sv/crm_ctrl.sv
sv/crm_dp.sv
sv/cycle_rate_meter_with_digit_format.sv
test/tb_cycle_rate_meter_with_digit_format.sv
